// File: hw/rtl/abhs_pkg.sv
// ----------------------------------------------------------------------------
// abhs_pkg: shared types and constants of the backlight smoother
// Register indexes, pipeline operation codes, fixed-point widths and the
// elapsed-time step coefficient used by the smoothing stage.
// ----------------------------------------------------------------------------
package abhs_pkg;

	localparam int SAMPLES_PER_TICK = 8;
	localparam int SAMPLE_W         = 12;
	localparam int SUM_W            = SAMPLE_W + $clog2(SAMPLES_PER_TICK + 1);
	localparam int LEVEL_W          = 8;
	localparam int FRAC_BITS        = 16;
	localparam int FX_W             = LEVEL_W + FRAC_BITS;
	localparam int TIME_W           = 32;
	localparam int INTERVAL_W       = 16;
	localparam int CFG_ADDR_W       = 3;
	localparam int CFG_DATA_W       = 16;

	// Step fraction: elapsed / 500 for elapsed below 500.
	localparam int                 FULL_STEP_MS = 500;
	localparam int                 E_W          = 9;
	// Coefficient ceil(e * 2^33 / 500); product with a 24-bit delta keeps the
	// truncated quotient exact since the error stays under 1/500.
	localparam int                 K_SHIFT      = 33;
	localparam int                 K_W          = 33;
	localparam logic [K_W:0]       STEP_K_INT   = 34'd17179869; // floor(2^31 / 125)
	localparam logic [13:0]        STEP_K_REM   = 14'd23;       // 2^31 mod 125
	localparam logic [13:0]        STEP_K_BIAS  = 14'd124;      // ceiling bias for /125
	localparam logic [28:0]        DIV125_MUL   = 29'd16778;    // ceil(2^21 / 125)
	localparam int                 DIV125_SHIFT = 21;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 8'd255;
	localparam logic [FX_W-1:0]    FX_HALF          = 24'h008000;
	localparam logic [FX_W-1:0]    LEVEL_RESET_FX   = 24'h640000;
	localparam logic [LEVEL_W-1:0] EMIT_RESET       = 8'd255;

	// Register reset values
	localparam logic                  AUTO_ENABLE_RST  = 1'b0;
	localparam logic [LEVEL_W-1:0]    START_LEVEL_RST  = 8'd100;
	localparam logic [LEVEL_W-1:0]    LEVEL_DARK_RST   = 8'd20;
	localparam logic [LEVEL_W-1:0]    LEVEL_LIGHT_RST  = 8'd100;
	localparam logic [SAMPLE_W-1:0]   DARK_ENTER_RST   = 12'd700;
	localparam logic [SAMPLE_W-1:0]   DARK_EXIT_RST    = 12'd400;
	localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 16'd100;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_AUTO_ENABLE  = 3'd0,
		REG_START_LEVEL  = 3'd1,
		REG_LEVEL_DARK   = 3'd2,
		REG_LEVEL_LIGHT  = 3'd3,
		REG_DARK_ENTER   = 3'd4,
		REG_DARK_EXIT    = 3'd5,
		REG_MIN_INTERVAL = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_NONE,  // bubble or dropped tick
		OP_LOAD,  // start tick: load level from start_level
		OP_STEP,  // partial move toward target
		OP_FULL   // jump to target
	} op_t;

	function automatic logic [K_W-1:0] step_coef(input logic [E_W-1:0] e);
		logic [K_W:0] base;
		logic [13:0]  rem;
		logic [28:0]  rq;
		base = {{(K_W + 1 - E_W){1'b0}}, e} * STEP_K_INT;
		rem  = {5'd0, e} * STEP_K_REM + STEP_K_BIAS;
		rq   = {15'd0, rem} * DIV125_MUL;
		return K_W'(base + {{(K_W + 1 - 8){1'b0}}, rq[DIV125_SHIFT +: 8]});
	endfunction

endpackage

// File: hw/rtl/auto_backlight_hysteresis_smoother.sv
// ----------------------------------------------------------------------------
// auto_backlight_hysteresis_smoother: ambient light backlight controller
// Averages light samples per tick, keeps a dark/light hysteresis flag and
// glides an 8.16 level toward the chosen target, emitting changes only.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one tick word: now_ms and eight
//   12-bit light samples. Output channel (out_valid/out_ready) carries a new
//   rounded backlight_level word, only when the rounded level changes, so a
//   tick yields zero or one output word.
//   The config port writes one register per cycle with cfg_wr_en; write only
//   while the block is idle (no ticks in flight).
// Path: a word accepted at the input is carried through the input register,
//   decision stage, coefficient stage and level stage to the output register.
// Throughput: one tick per cycle unless an output word waits; the level
//   recurrence closes in the last stage (one 24x33 multiply plus add), the
//   timestamp/flag recurrence in the decision stage.
// Reset: registers return to their documented defaults, the smoother is
//   unstarted, level is 100.0 and the last emitted level reads as 255.
// Stall: while an output word waits with out_ready low the whole pipeline
//   holds and in_ready drops; it resumes the cycle the word is taken.
// ----------------------------------------------------------------------------
module auto_backlight_hysteresis_smoother (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [abhs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [abhs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// tick input
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [abhs_pkg::TIME_W-1:0]          now_ms,
	input  logic [abhs_pkg::SAMPLE_W-1:0]        sample_0,
	input  logic [abhs_pkg::SAMPLE_W-1:0]        sample_1,
	input  logic [abhs_pkg::SAMPLE_W-1:0]        sample_2,
	input  logic [abhs_pkg::SAMPLE_W-1:0]        sample_3,
	input  logic [abhs_pkg::SAMPLE_W-1:0]        sample_4,
	input  logic [abhs_pkg::SAMPLE_W-1:0]        sample_5,
	input  logic [abhs_pkg::SAMPLE_W-1:0]        sample_6,
	input  logic [abhs_pkg::SAMPLE_W-1:0]        sample_7,
	// level output
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [abhs_pkg::LEVEL_W-1:0]         backlight_level
);

	// ---------------- configuration registers ----------------
	logic                                auto_enable_q;
	logic [abhs_pkg::LEVEL_W-1:0]        start_level_q;
	logic [abhs_pkg::LEVEL_W-1:0]        level_dark_q;
	logic [abhs_pkg::LEVEL_W-1:0]        level_light_q;
	logic [abhs_pkg::SAMPLE_W-1:0]       dark_enter_q;
	logic [abhs_pkg::SAMPLE_W-1:0]       dark_exit_q;
	logic [abhs_pkg::INTERVAL_W-1:0]     min_interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_enable_q  <= abhs_pkg::AUTO_ENABLE_RST;
			start_level_q  <= abhs_pkg::START_LEVEL_RST;
			level_dark_q   <= abhs_pkg::LEVEL_DARK_RST;
			level_light_q  <= abhs_pkg::LEVEL_LIGHT_RST;
			dark_enter_q   <= abhs_pkg::DARK_ENTER_RST;
			dark_exit_q    <= abhs_pkg::DARK_EXIT_RST;
			min_interval_q <= abhs_pkg::MIN_INTERVAL_RST;
		end else if (cfg_wr_en) begin
			// writes beyond the register list are dropped
			unique case (cfg_addr)
				abhs_pkg::REG_AUTO_ENABLE:  auto_enable_q  <= cfg_wdata[0];
				abhs_pkg::REG_START_LEVEL:  start_level_q  <= cfg_wdata[abhs_pkg::LEVEL_W-1:0];
				abhs_pkg::REG_LEVEL_DARK:   level_dark_q   <= cfg_wdata[abhs_pkg::LEVEL_W-1:0];
				abhs_pkg::REG_LEVEL_LIGHT:  level_light_q  <= cfg_wdata[abhs_pkg::LEVEL_W-1:0];
				abhs_pkg::REG_DARK_ENTER:   dark_enter_q   <= cfg_wdata[abhs_pkg::SAMPLE_W-1:0];
				abhs_pkg::REG_DARK_EXIT:    dark_exit_q    <= cfg_wdata[abhs_pkg::SAMPLE_W-1:0];
				abhs_pkg::REG_MIN_INTERVAL: min_interval_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline flow ----------------
	// All stages move together; they hold only while an output word waits.
	logic advance;
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// ---------------- input register ----------------
	logic                                valid_s1;
	logic [abhs_pkg::TIME_W-1:0]         now_s1;
	logic [abhs_pkg::SAMPLE_W-1:0]       samp_s1 [abhs_pkg::SAMPLES_PER_TICK];
	logic [abhs_pkg::SAMPLE_W-1:0]       samp_in [8];

	assign samp_in[0] = sample_0;
	assign samp_in[1] = sample_1;
	assign samp_in[2] = sample_2;
	assign samp_in[3] = sample_3;
	assign samp_in[4] = sample_4;
	assign samp_in[5] = sample_5;
	assign samp_in[6] = sample_6;
	assign samp_in[7] = sample_7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			now_s1 <= now_ms;
			for (int i = 0; i < abhs_pkg::SAMPLES_PER_TICK; i++) begin
				samp_s1[i] <= samp_in[i];
			end
		end
	end

	// ---------------- decision stage ----------------
	// Gating (auto mode, start tick, interval), average and hysteresis flag.
	logic                                started_q;
	logic                                dark_q;
	logic [abhs_pkg::TIME_W-1:0]         last_tick_q;

	logic [abhs_pkg::TIME_W-1:0]         elapsed;
	logic                                too_soon;
	logic                                full_step;
	logic [abhs_pkg::SUM_W-1:0]          sample_sum;
	logic [abhs_pkg::SAMPLE_W-1:0]       avg;
	logic                                dark_next;
	abhs_pkg::op_t                       op_a;
	logic [abhs_pkg::LEVEL_W-1:0]        tgt_a;

	always_comb begin
		sample_sum = '0;
		for (int i = 0; i < abhs_pkg::SAMPLES_PER_TICK; i++) begin
			sample_sum = sample_sum + abhs_pkg::SUM_W'(samp_s1[i]);
		end
	end

	assign avg       = abhs_pkg::SAMPLE_W'(sample_sum / abhs_pkg::SAMPLES_PER_TICK);
	assign elapsed   = now_s1 - last_tick_q;
	assign too_soon  = elapsed < abhs_pkg::TIME_W'(min_interval_q);
	assign full_step = elapsed >= abhs_pkg::TIME_W'(abhs_pkg::FULL_STEP_MS);

	// only one of the two thresholds applies per tick
	always_comb begin
		dark_next = dark_q;
		if (!dark_q && avg > dark_enter_q) begin
			dark_next = 1'b1;
		end else if (dark_q && avg < dark_exit_q) begin
			dark_next = 1'b0;
		end
	end

	always_comb begin
		op_a  = abhs_pkg::OP_NONE;
		tgt_a = dark_next ? level_dark_q : level_light_q;
		priority if (!valid_s1 || !auto_enable_q) begin
			op_a = abhs_pkg::OP_NONE;
		end else if (!started_q) begin
			op_a  = abhs_pkg::OP_LOAD;
			tgt_a = start_level_q;
		end else if (too_soon) begin
			op_a = abhs_pkg::OP_NONE;
		end else if (full_step) begin
			op_a = abhs_pkg::OP_FULL;
		end else begin
			op_a = abhs_pkg::OP_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			dark_q      <= 1'b0;
			last_tick_q <= '0;
		end else if (advance && valid_s1) begin
			if (!auto_enable_q) begin
				started_q <= 1'b0;
			end else if (!started_q) begin
				started_q   <= 1'b1;
				last_tick_q <= now_s1;
			end else if (!too_soon) begin
				last_tick_q <= now_s1;
				dark_q      <= dark_next;
			end
		end
	end

	// ---------------- coefficient stage ----------------
	abhs_pkg::op_t                       op_s2;
	logic [abhs_pkg::LEVEL_W-1:0]        tgt_s2;
	logic [abhs_pkg::E_W-1:0]            e_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2 <= abhs_pkg::OP_NONE;
		end else if (advance) begin
			op_s2 <= op_a;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tgt_s2 <= tgt_a;
			e_s2   <= elapsed[abhs_pkg::E_W-1:0];
		end
	end

	abhs_pkg::op_t                       op_s3;
	logic [abhs_pkg::LEVEL_W-1:0]        tgt_s3;
	logic [abhs_pkg::K_W-1:0]            k_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s3 <= abhs_pkg::OP_NONE;
		end else if (advance) begin
			op_s3 <= op_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tgt_s3 <= tgt_s2;
			k_s3   <= abhs_pkg::step_coef(e_s2);
		end
	end

	// ---------------- level stage ----------------
	logic [abhs_pkg::FX_W-1:0]           level_q;
	logic [abhs_pkg::LEVEL_W-1:0]        last_emit_q;
	logic [abhs_pkg::LEVEL_W-1:0]        out_level_q;
	logic                                out_valid_q;

	logic [abhs_pkg::FX_W-1:0]           tgt_fx;
	logic                                rising;
	logic [abhs_pkg::FX_W-1:0]           mag;
	logic [abhs_pkg::FX_W+abhs_pkg::K_W-1:0] prod;
	logic [abhs_pkg::FX_W-1:0]           delta;
	logic [abhs_pkg::FX_W-1:0]           level_next;
	logic [abhs_pkg::FX_W:0]             rnd_sum;
	logic [abhs_pkg::LEVEL_W-1:0]        rnd_level;
	logic                                do_move;

	assign tgt_fx  = {tgt_s3, {abhs_pkg::FRAC_BITS{1'b0}}};
	assign rising  = tgt_fx >= level_q;
	assign mag     = rising ? (tgt_fx - level_q) : (level_q - tgt_fx);
	assign prod    = {{abhs_pkg::K_W{1'b0}}, mag} * {{abhs_pkg::FX_W{1'b0}}, k_s3};
	assign delta   = prod[abhs_pkg::K_SHIFT +: abhs_pkg::FX_W];
	assign do_move = (op_s3 == abhs_pkg::OP_STEP) || (op_s3 == abhs_pkg::OP_FULL);

	always_comb begin
		unique case (op_s3)
			abhs_pkg::OP_FULL: level_next = tgt_fx;
			abhs_pkg::OP_STEP: level_next = rising ? (level_q + delta) : (level_q - delta);
			abhs_pkg::OP_LOAD: level_next = tgt_fx;
			default:           level_next = level_q;
		endcase
	end

	// round to nearest integer level, saturate at full scale
	assign rnd_sum   = {1'b0, level_next} + {1'b0, abhs_pkg::FX_HALF};
	assign rnd_level = (rnd_sum[abhs_pkg::FX_W:abhs_pkg::FRAC_BITS] >
			{1'b0, abhs_pkg::LEVEL_MAX}) ? abhs_pkg::LEVEL_MAX :
			rnd_sum[abhs_pkg::FRAC_BITS +: abhs_pkg::LEVEL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= abhs_pkg::LEVEL_RESET_FX;
			last_emit_q <= abhs_pkg::EMIT_RESET;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			level_q     <= level_next;
			out_valid_q <= 1'b0;
			if (do_move && rnd_level != last_emit_q) begin
				last_emit_q <= rnd_level;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && do_move) begin
			out_level_q <= rnd_level;
		end
	end

	assign out_valid       = out_valid_q;
	assign backlight_level = out_level_q;

endmodule

// File: hw/rtl/abhs_checker.sv
// ----------------------------------------------------------------------------
// abhs_checker: port-level checks of the backlight smoother
// Watches the handshakes and the emitted levels seen at the top-level ports.
// ----------------------------------------------------------------------------
module abhs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [abhs_pkg::LEVEL_W-1:0]  backlight_level
);

	// last level taken by the receiver
	logic [abhs_pkg::LEVEL_W-1:0] prev_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= abhs_pkg::EMIT_RESET;
		end else if (out_valid && out_ready) begin
			prev_level_q <= backlight_level;
		end
	end

	// a waiting word holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(backlight_level))
		else $error("output word changed while stalled");

	// every emitted level differs from the one before
	a_out_changes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> backlight_level != prev_level_q)
		else $error("repeated backlight level emitted");

	// input side stalls only behind a waiting output word
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a new output word needs the pipeline to have moved the cycle before
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("output word appeared while pipeline held");

	// an offered tick word stays offered until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input word withdrawn before it was taken");

endmodule

bind auto_backlight_hysteresis_smoother abhs_checker u_abhs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.backlight_level (backlight_level)
);

// File: sim/tb_auto_backlight_hysteresis_smoother.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_auto_backlight_hysteresis_smoother: self-checking bench of the smoother
// A queue-fed driver offers tick words with random gaps. A clocked monitor
// stalls the output at random and checks each level word against a
// cycle-free model of the hysteresis and 8.16 glide. The bench runs directed
// corner ticks, then several register settings with random ticks, then a
// long output hold-off that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module tb_auto_backlight_hysteresis_smoother;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 8;      // lets the pipeline stages drain
	localparam int HOLD_CYCLES   = 300;    // long output hold-off
	localparam int CYCLE_LIMIT   = 400000;

	// One tick word: timestamp plus eight light samples
	typedef struct packed {
		logic [abhs_pkg::TIME_W-1:0]                                  stamp;
		logic [abhs_pkg::SAMPLES_PER_TICK-1:0][abhs_pkg::SAMPLE_W-1:0] smp;
	} tick_t;

	// DUT ports
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [abhs_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [abhs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [abhs_pkg::TIME_W-1:0]     now_ms = '0;
	logic [abhs_pkg::SAMPLE_W-1:0]   sample_0 = '0, sample_1 = '0, sample_2 = '0;
	logic [abhs_pkg::SAMPLE_W-1:0]   sample_3 = '0, sample_4 = '0, sample_5 = '0;
	logic [abhs_pkg::SAMPLE_W-1:0]   sample_6 = '0, sample_7 = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [abhs_pkg::LEVEL_W-1:0]    backlight_level;

	// Register copies, kept in step with every write
	logic                            m_auto      = abhs_pkg::AUTO_ENABLE_RST;
	logic [abhs_pkg::LEVEL_W-1:0]    m_start     = abhs_pkg::START_LEVEL_RST;
	logic [abhs_pkg::LEVEL_W-1:0]    m_dark_lvl  = abhs_pkg::LEVEL_DARK_RST;
	logic [abhs_pkg::LEVEL_W-1:0]    m_light_lvl = abhs_pkg::LEVEL_LIGHT_RST;
	logic [abhs_pkg::SAMPLE_W-1:0]   m_enter     = abhs_pkg::DARK_ENTER_RST;
	logic [abhs_pkg::SAMPLE_W-1:0]   m_exit      = abhs_pkg::DARK_EXIT_RST;
	logic [abhs_pkg::INTERVAL_W-1:0] m_interval  = abhs_pkg::MIN_INTERVAL_RST;

	// Smoother state as it should be after each accepted tick
	logic                            m_started  = 1'b0;
	logic                            m_dark     = 1'b0;
	logic [abhs_pkg::FX_W-1:0]       m_level    = abhs_pkg::LEVEL_RESET_FX;
	logic [abhs_pkg::TIME_W-1:0]     m_last_ms  = '0;
	logic [abhs_pkg::LEVEL_W-1:0]    m_last_out = abhs_pkg::EMIT_RESET;

	tick_t                        tick_queue[$];   // ticks waiting for the driver
	logic [abhs_pkg::LEVEL_W-1:0] level_queue[$];  // level words still to come out

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  idle_on        = 1'b1;   // random gaps and stalls enabled
	bit  pressure_req   = 1'b0;
	bit  pressure_done  = 1'b0;
	int  hold_left      = 0;
	int  stall_left     = 0;
	int  gap_left       = 0;
	tick_t drv_tick;
	logic [abhs_pkg::TIME_W-1:0] t_ms = '0;

	auto_backlight_hysteresis_smoother DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.now_ms          (now_ms),
		.sample_0        (sample_0),
		.sample_1        (sample_1),
		.sample_2        (sample_2),
		.sample_3        (sample_3),
		.sample_4        (sample_4),
		.sample_5        (sample_5),
		.sample_6        (sample_6),
		.sample_7        (sample_7),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.backlight_level (backlight_level)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Advance the smoother model by one accepted tick; return 1 when the
	// rounded level changes and a word must come out.
	function automatic bit predict_level(input tick_t t,
	                                     output logic [abhs_pkg::LEVEL_W-1:0] lvl);
		logic [abhs_pkg::TIME_W-1:0]   elapsed;
		logic [14:0]                   sum;
		logic [abhs_pkg::SAMPLE_W-1:0] avg;
		logic [abhs_pkg::FX_W-1:0]     goal;
		logic [abhs_pkg::FX_W-1:0]     span;
		logic [63:0]                   prod;
		logic [31:0]                   rnd;
		logic [abhs_pkg::LEVEL_W-1:0]  lvl8;
		lvl = '0;
		// Auto off: drop the started flag, keep the rest
		if (!m_auto) begin
			m_started = 1'b0;
			return 1'b0;
		end
		// Start tick: record the time and load the start level
		if (!m_started) begin
			m_last_ms = t.stamp;
			m_level   = {m_start, 16'h0000};
			m_started = 1'b1;
			return 1'b0;
		end
		// Short interval (modulo 2^32): tick is ignored
		elapsed = t.stamp - m_last_ms;
		if (elapsed < {16'h0000, m_interval})
			return 1'b0;
		m_last_ms = t.stamp;

		sum = '0;
		for (int i = 0; i < abhs_pkg::SAMPLES_PER_TICK; i++)
			sum = sum + 15'(t.smp[i]);
		avg = abhs_pkg::SAMPLE_W'(sum / abhs_pkg::SAMPLES_PER_TICK);

		// Hysteresis: only one of the two tests applies per tick
		if (!m_dark && avg > m_enter)
			m_dark = 1'b1;
		else if (m_dark && avg < m_exit)
			m_dark = 1'b0;

		goal = {(m_dark ? m_dark_lvl : m_light_lvl), 16'h0000};
		if (elapsed >= abhs_pkg::FULL_STEP_MS) begin
			m_level = goal;
		end else if (goal >= m_level) begin
			span    = goal - m_level;
			prod    = 64'(span) * 64'(elapsed);
			m_level = m_level + abhs_pkg::FX_W'(prod / abhs_pkg::FULL_STEP_MS);
		end else begin
			span    = m_level - goal;
			prod    = 64'(span) * 64'(elapsed);
			m_level = m_level - abhs_pkg::FX_W'(prod / abhs_pkg::FULL_STEP_MS);
		end

		// Round to nearest, saturate at full scale
		rnd  = (32'(m_level) + 32'h8000) >> abhs_pkg::FRAC_BITS;
		lvl8 = (rnd > 32'd255) ? abhs_pkg::LEVEL_MAX : rnd[7:0];
		if (lvl8 != m_last_out) begin
			m_last_out = lvl8;
			lvl        = lvl8;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Mostly zero, some short, a few long
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [abhs_pkg::SAMPLE_W-1:0] clamp12(input int v);
		if (v < 0) return '0;
		if (v > 4095) return 12'hFFF;
		return v[abhs_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic tick_t flat_tick(input logic [abhs_pkg::TIME_W-1:0] stamp,
	                                    input logic [abhs_pkg::SAMPLE_W-1:0] v);
		tick_t t;
		t.stamp = stamp;
		for (int i = 0; i < abhs_pkg::SAMPLES_PER_TICK; i++)
			t.smp[i] = v;
		return t;
	endfunction

	// Random samples: uniform noise, threshold hits, or clusters on either
	// side of the hysteresis band so that the flag really toggles.
	function automatic tick_t random_tick(input logic [abhs_pkg::TIME_W-1:0] stamp);
		tick_t t;
		int    mode;
		int    center;
		t.stamp = stamp;
		mode = $urandom_range(0, 9);
		if (mode < 3) begin
			for (int i = 0; i < abhs_pkg::SAMPLES_PER_TICK; i++)
				t.smp[i] = abhs_pkg::SAMPLE_W'($urandom());
		end else if (mode == 3) begin
			center = $urandom_range(0, 1) ? int'(m_enter) : int'(m_exit);
			t = flat_tick(stamp, clamp12(center + $urandom_range(0, 2) - 1));
		end else begin
			if ($urandom_range(0, 1))
				center = int'(m_enter) + $urandom_range(1, 600);
			else
				center = int'(m_exit) - $urandom_range(1, 400);
			for (int i = 0; i < abhs_pkg::SAMPLES_PER_TICK; i++)
				t.smp[i] = clamp12(center + $urandom_range(0, 200) - 100);
		end
		return t;
	endfunction

	// Time step between ticks: mostly a valid interval, some too short, some
	// long enough for a full step, a few wild jumps that wrap the counter.
	function automatic logic [abhs_pkg::TIME_W-1:0] next_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10 && m_interval != 0)
			return abhs_pkg::TIME_W'($urandom_range(0, int'(m_interval) - 1));
		if (r < 15)
			return abhs_pkg::TIME_W'($urandom());
		if (r < 30)
			return abhs_pkg::TIME_W'($urandom_range(500, 2000));
		return abhs_pkg::TIME_W'(m_interval) + abhs_pkg::TIME_W'($urandom_range(0, 499));
	endfunction

	// Random bits above the register width; the block must drop them
	function automatic logic [abhs_pkg::CFG_DATA_W-1:0] with_junk(
			input logic [abhs_pkg::CFG_DATA_W-1:0] v, input int w, input bit junk);
		if (!junk || w >= abhs_pkg::CFG_DATA_W) return v;
		return v | (abhs_pkg::CFG_DATA_W'($urandom()) << w);
	endfunction

	task automatic write_reg(input abhs_pkg::cfg_idx_t idx,
	                         input logic [abhs_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			abhs_pkg::REG_AUTO_ENABLE:  m_auto      = val[0];
			abhs_pkg::REG_START_LEVEL:  m_start     = val[7:0];
			abhs_pkg::REG_LEVEL_DARK:   m_dark_lvl  = val[7:0];
			abhs_pkg::REG_LEVEL_LIGHT:  m_light_lvl = val[7:0];
			abhs_pkg::REG_DARK_ENTER:   m_enter     = val[11:0];
			abhs_pkg::REG_DARK_EXIT:    m_exit      = val[11:0];
			abhs_pkg::REG_MIN_INTERVAL: m_interval  = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic auto_en, input logic [7:0] start,
	                          input logic [7:0] dark_lvl, input logic [7:0] light_lvl,
	                          input logic [11:0] enter, input logic [11:0] leave,
	                          input logic [15:0] interval, input bit junk);
		write_reg(abhs_pkg::REG_AUTO_ENABLE,  with_junk(16'(auto_en), 1, junk));
		write_reg(abhs_pkg::REG_START_LEVEL,  with_junk(16'(start), 8, junk));
		write_reg(abhs_pkg::REG_LEVEL_DARK,   with_junk(16'(dark_lvl), 8, junk));
		write_reg(abhs_pkg::REG_LEVEL_LIGHT,  with_junk(16'(light_lvl), 8, junk));
		write_reg(abhs_pkg::REG_DARK_ENTER,   with_junk(16'(enter), 12, junk));
		write_reg(abhs_pkg::REG_DARK_EXIT,    with_junk(16'(leave), 12, junk));
		write_reg(abhs_pkg::REG_MIN_INTERVAL, interval);
	endtask

	// Wait until every tick is taken and every level word is back, then let
	// the pipeline empty out ticks that produce no word.
	task automatic settle();
		while (tick_queue.size() != 0 || in_valid || level_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			t_ms = t_ms + next_delta();
			tick_queue.push_back(random_tick(t_ms));
		end
	endtask

	// Driver: hold a word until taken, then insert a gap or offer the next.
	always @(posedge clk) begin
		logic [abhs_pkg::LEVEL_W-1:0] lvl;
		bit                           accept;
		if (arst_n) begin
			accept = in_valid && in_ready;
			if (accept && predict_level(drv_tick, lvl))
				level_queue.push_back(lvl);
			if (!in_valid || accept) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (tick_queue.size() != 0) begin
					drv_tick = tick_queue.pop_front();
					now_ms   <= drv_tick.stamp;
					sample_0 <= drv_tick.smp[0];
					sample_1 <= drv_tick.smp[1];
					sample_2 <= drv_tick.smp[2];
					sample_3 <= drv_tick.smp[3];
					sample_4 <= drv_tick.smp[4];
					sample_5 <= drv_tick.smp[5];
					sample_6 <= drv_tick.smp[6];
					sample_7 <= drv_tick.smp[7];
					in_valid <= 1'b1;
					gap_left = idle_on ? rand_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each taken word, then pick the next ready value.
	always @(posedge clk) begin
		logic [abhs_pkg::LEVEL_W-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (level_queue.size() == 0) begin
					$error("backlight_level: unexpected word %0d", backlight_level);
					mismatch_count++;
				end else begin
					want = level_queue.pop_front();
					if (backlight_level !== want) begin
						$error("backlight_level: expected %0d, actual %0d", want,
						       backlight_level);
						mismatch_count++;
					end
				end
			end
			// Start the long hold-off once, when asked
			if (pressure_req && !pressure_done) begin
				hold_left     = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = rand_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: auto off after reset, nothing must come out
		tick_queue.push_back(flat_tick(32'd5, 12'hFFF));
		tick_queue.push_back(flat_tick(32'd10, 12'h000));
		settle();
		write_reg(abhs_pkg::REG_AUTO_ENABLE, 16'd1);

		// Start tick, short interval, dark entry, full step, light return
		tick_queue.push_back(flat_tick(32'd1000, 12'h000));
		tick_queue.push_back(flat_tick(32'd1050, 12'hFFF));
		tick_queue.push_back(flat_tick(32'd1100, 12'hFFF));
		tick_queue.push_back(flat_tick(32'd1700, 12'hFFF));
		tick_queue.push_back(flat_tick(32'd1800, 12'h000));
		// Inside the band, then on each threshold (flag holds), each followed by a flip
		tick_queue.push_back(flat_tick(32'd1900, 12'd500));
		tick_queue.push_back(flat_tick(32'd2000, 12'd700));
		tick_queue.push_back(flat_tick(32'd2100, 12'hFFF));
		tick_queue.push_back(flat_tick(32'd2200, 12'd400));
		tick_queue.push_back(flat_tick(32'd2300, 12'd399));
		// Toggling bit patterns in the samples
		tick_queue.push_back({32'd2450, {4{12'hFFF, 12'h000}}});
		tick_queue.push_back({32'd2600, {4{12'hAAA, 12'h555}}});
		// Timestamp wrap: a huge jump, then a step across zero
		tick_queue.push_back(flat_tick(32'hFFFF_FF00, 12'hFFF));
		tick_queue.push_back(flat_tick(32'h0000_0050, 12'h000));
		settle();

		// Zero interval: a tick with no elapsed time still moves the flag
		write_reg(abhs_pkg::REG_MIN_INTERVAL, 16'd0);
		tick_queue.push_back(flat_tick(32'h0000_0050, 12'hFFF));
		tick_queue.push_back(flat_tick(32'h0000_0140, 12'hFFF));
		settle();

		// Restart at full scale and round at the top of the level range
		set_config(1'b0, 8'd255, 8'd0, 8'd255, 12'd4095, 12'd0, 16'd0, 1'b0);
		tick_queue.push_back(flat_tick(32'h0000_0200, 12'h800));
		settle();
		write_reg(abhs_pkg::REG_AUTO_ENABLE, 16'd1);
		tick_queue.push_back(flat_tick(32'h0000_0300, 12'h000));
		tick_queue.push_back(flat_tick(32'h0000_04F4, 12'h000));
		tick_queue.push_back(flat_tick(32'h0000_0700, 12'hFFF));
		t_ms = 32'h0000_0700;

		// Random phases under several register settings
		for (int p = 0; p < 7; p++) begin
			int iv_sel;
			logic [15:0] iv;
			settle();
			idle_on = (p % 3 != 2);
			iv_sel  = $urandom_range(0, 3);
			case (iv_sel)
				0:       iv = 16'd0;
				1:       iv = 16'($urandom_range(1, 20));
				2:       iv = 16'd100;
				default: iv = 16'($urandom_range(200, 600));
			endcase
			case (p)
				1: set_config(1'b1, 8'd255, 8'd0, 8'd255, 12'd0, 12'd4095, 16'd0, 1'b1);
				3: set_config(1'b0, 8'($urandom()), 8'($urandom()), 8'($urandom()),
				              12'($urandom()), 12'($urandom()), iv, 1'b1);
				4: set_config(1'b1, 8'd0, 8'd255, 8'd0, 12'd4095, 12'd0, 16'hFFFF, 1'b1);
				default: set_config(1'b1, 8'($urandom()), 8'($urandom()), 8'($urandom()),
				                    12'($urandom()), 12'($urandom()), iv, 1'b1);
			endcase
			run_ticks((p == 3) ? 15 : 125);
		end

		// Back-pressure: hold the output while ticks keep coming; the ticks alternate
		// dark and light so that nearly every tick flips the flag and emits a word.
		settle();
		set_config(1'b1, 8'd128, 8'd0, 8'd255, 12'd2000, 12'd1000, 16'd1, 1'b0);
		idle_on      = 1'b0;
		pressure_req = 1'b1;
		tick_queue.push_back(flat_tick(t_ms, 12'h000));
		for (int i = 0; i < 60; i++) begin
			t_ms = t_ms + 32'd100;
			tick_queue.push_back(flat_tick(t_ms, (i % 2 == 0) ? 12'hFFF : 12'h000));
		end

		settle();
		if (level_queue.size() != 0) begin
			$error("backlight_level: %0d expected words never arrived", level_queue.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/abhs_pkg.sv
hw/rtl/auto_backlight_hysteresis_smoother.sv
hw/rtl/abhs_checker.sv
sim/tb_auto_backlight_hysteresis_smoother.sv
